// ----- hw/rtl/toa_pkg.sv -----
// shared types, widths and constants of the lora time-on-air block
`default_nettype none

package toa_pkg;

  localparam int unsigned LEN_W     = 8;
  localparam int unsigned MS_W      = 23;
  localparam int unsigned SF_W      = 4;
  localparam int unsigned BW_W      = 19;
  localparam int unsigned CR_W      = 3;
  localparam int unsigned PRE_W     = 10;
  localparam int unsigned CFG_W     = 19;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SF  = 3'd0,
    CFG_BW  = 3'd1,
    CFG_CR  = 3'd2,
    CFG_PRE = 3'd3,
    CFG_CRC = 3'd4
  } cfg_idx_t;

  localparam logic [SF_W-1:0]  SF_MIN   = 4'd5;
  localparam logic [SF_W-1:0]  SF_MAX   = 4'd12;
  localparam logic [SF_W-1:0]  SF_LDRO  = 4'd11;
  localparam logic [SF_W-1:0]  SF_RST   = 4'd7;
  localparam logic [BW_W-1:0]  BW_RST   = 19'd125000;
  localparam logic [CR_W-1:0]  CR_RST   = 3'd1;
  localparam logic [PRE_W-1:0] PRE_RST  = 10'd8;

  localparam int unsigned SYM_DIV_STAGES = 32;
  localparam int unsigned MS_X_W         = 34;
  localparam int unsigned LATENCY        = 3 + SYM_DIV_STAGES + 2 + 1 + 1;

  localparam logic [SYM_DIV_STAGES-1:0] US_PER_S   = 32'd1000000;
  localparam logic [MS_W-1:0]           MS_MAX     = 23'h7FFFFF;
  localparam logic [9:0]                MS_ROUND   = 10'd999;
  localparam logic [7:0]                ACK_MS     = 8'd200;
  localparam logic [LEN_W-1:0]          ACK_LEN    = 8'd8;

  // ceil(2^38 / 125), exact floor(n / 125) for n below 2^31
  localparam logic [31:0]               MS_RECIP   = 32'd2199023256;

  // ceil(2^16 / d), exact floor(n / d) for n below 1024
  function automatic logic [13:0] recip16(input logic [3:0] d);
    logic [13:0] m;
    case (d)
      4'd5:    m = 14'd13108;
      4'd6:    m = 14'd10923;
      4'd7:    m = 14'd9363;
      4'd8:    m = 14'd8192;
      4'd9:    m = 14'd7282;
      4'd10:   m = 14'd6554;
      default: m = 14'd0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lora_time_on_air_core.sv -----
// lora time-on-air and ack timeout calculator, fully pipelined
// pipeline order: ceiling stages, symbol-time divider, scaling, ms division, output register
// throughput: one item per cycle; busy is low whenever rst_n is high
// the 32-stage symbol-time divider sets most of the latency
// synchronous active-low reset restores the config defaults and empties the pipe
`default_nettype none

module lora_time_on_air_core (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire                               in_operation,
  input  wire  [toa_pkg::LEN_W-1:0]         in_payload_len,
  input  wire                               cfg_we,
  input  wire  [toa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [toa_pkg::CFG_W-1:0]         cfg_wdata,
  output logic                              out_valid,
  output logic [toa_pkg::MS_W-1:0]          out_time_ms
);

  import toa_pkg::*;

  localparam int unsigned SD = SYM_DIV_STAGES;
  localparam int unsigned KD = MS_X_W;
  localparam logic [13:0] Q_BASE = 14'd49;

  // configuration
  logic [SF_W-1:0]  sf_r;
  logic [BW_W-1:0]  bw_r;
  logic [CR_W-1:0]  cr_r;
  logic [PRE_W-1:0] pre_r;
  logic             crc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r  <= SF_RST;
      bw_r  <= BW_RST;
      cr_r  <= CR_RST;
      pre_r <= PRE_RST;
      crc_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SF:  sf_r  <= cfg_wdata[SF_W-1:0];
        CFG_BW:  bw_r  <= cfg_wdata[BW_W-1:0];
        CFG_CR:  cr_r  <= cfg_wdata[CR_W-1:0];
        CFG_PRE: pre_r <= cfg_wdata[PRE_W-1:0];
        CFG_CRC: crc_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  logic [SF_W-1:0]  sf_c;
  logic [SF_W-1:0]  den_c;
  logic [BW_W-1:0]  bw_c;
  logic [13:0]      recip_c;
  logic [3:0]       crm_c;
  logic [SD-1:0]    sym_num_c;

  always_comb begin
    if (sf_r < SF_MIN) begin
      sf_c = SF_MIN;
    end else if (sf_r > SF_MAX) begin
      sf_c = SF_MAX;
    end else begin
      sf_c = sf_r;
    end
    den_c     = (sf_c >= SF_LDRO) ? sf_c - 4'd2 : sf_c;
    bw_c      = (bw_r == '0) ? 19'd1 : bw_r;
    recip_c   = recip16(den_c);
    crm_c     = {1'b0, cr_r} + 4'd4;
    sym_num_c = US_PER_S << sf_c;
  end

  assign busy = ~rst_n;

  // payload symbol numerator over 4, ceiling bias added, zero when not positive
  function automatic logic [9:0] ceil_num(input logic [9:0] pos, input logic [3:0] sf,
                                          input logic [3:0] den);
    logic [9:0] n;
    n = '0;
    if (pos > {6'b0, sf}) begin
      n = pos - {6'b0, sf} + {6'b0, den} - 10'd1;
    end
    return n;
  endfunction

  logic       accept;
  logic [9:0] pos_a;
  logic [9:0] pos_b;

  assign accept = start & ~busy;
  assign pos_a  = {1'b0, in_payload_len, 1'b0} + 10'd7 + {7'b0, crc_r, 2'b0};
  assign pos_b  = {1'b0, ACK_LEN, 1'b0} + 10'd7 + {7'b0, crc_r, 2'b0};

  // stage 1: ceiling numerators
  logic       e1_v_r;
  logic       e1_op_r;
  logic [9:0] e1_na_r;
  logic [9:0] e1_nb_r;

  // stage 2: payload symbol blocks
  logic       e2_v_r;
  logic       e2_op_r;
  logic [7:0] e2_ca_r;
  logic [7:0] e2_cb_r;

  // stage 3: total symbols times four
  logic        e3_v_r;
  logic        e3_op_r;
  logic [13:0] e3_qa_r;
  logic [13:0] e3_qb_r;

  logic [23:0] e2_pa;
  logic [23:0] e2_pb;
  logic [11:0] e3_da;
  logic [11:0] e3_db;

  assign e2_pa = 24'(e1_na_r) * 24'(recip_c);
  assign e2_pb = 24'(e1_nb_r) * 24'(recip_c);
  assign e3_da = 12'(e2_ca_r) * 12'(crm_c);
  assign e3_db = 12'(e2_cb_r) * 12'(crm_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      e3_v_r <= 1'b0;
    end else begin
      e1_v_r <= accept;
      e2_v_r <= e1_v_r;
      e3_v_r <= e2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    e1_op_r <= in_operation;
    e1_na_r <= ceil_num(pos_a, sf_c, den_c);
    e1_nb_r <= ceil_num(pos_b, sf_c, den_c);
    e2_op_r <= e1_op_r;
    e2_ca_r <= e2_pa[23:16];
    e2_cb_r <= e2_pb[23:16];
    e3_op_r <= e2_op_r;
    e3_qa_r <= {2'b0, pre_r, 2'b0} + Q_BASE + {e3_da, 2'b0};
    e3_qb_r <= {2'b0, pre_r, 2'b0} + Q_BASE + {e3_db, 2'b0};
  end

  // symbol time divider, one quotient bit per stage
  logic [SD-1:0]   sd_v_r;
  logic            sd_op_r  [SD];
  logic [13:0]     sd_qa_r  [SD];
  logic [13:0]     sd_qb_r  [SD];
  logic [SD-1:0]   sd_dq_r  [SD];
  logic [BW_W-1:0] sd_rem_r [SD];
  logic [SD-1:0]   sd_dq_nxt  [SD];
  logic [BW_W-1:0] sd_rem_nxt [SD];

  always_comb begin
    logic [SD-1:0]   dq_in;
    logic [BW_W-1:0] rem_in;
    logic [BW_W:0]   t;
    logic            ge;
    for (int s = 0; s < SD; s++) begin
      if (s == 0) begin
        dq_in  = sym_num_c;
        rem_in = '0;
      end else begin
        dq_in  = sd_dq_r[s-1];
        rem_in = sd_rem_r[s-1];
      end
      t             = {rem_in, dq_in[SD-1]};
      ge            = (t >= {1'b0, bw_c});
      sd_rem_nxt[s] = ge ? BW_W'(t - {1'b0, bw_c}) : t[BW_W-1:0];
      sd_dq_nxt[s]  = {dq_in[SD-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_v_r <= '0;
    end else begin
      sd_v_r <= {sd_v_r[SD-2:0], e3_v_r};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SD; s++) begin
      sd_dq_r[s]  <= sd_dq_nxt[s];
      sd_rem_r[s] <= sd_rem_nxt[s];
      if (s == 0) begin
        sd_op_r[s] <= e3_op_r;
        sd_qa_r[s] <= e3_qa_r;
        sd_qb_r[s] <= e3_qb_r;
      end else begin
        sd_op_r[s] <= sd_op_r[s-1];
        sd_qa_r[s] <= sd_qa_r[s-1];
        sd_qb_r[s] <= sd_qb_r[s-1];
      end
    end
  end

  // microseconds times four, then clamped and biased for the ms ceiling
  logic        m_v_r;
  logic        m_op_r;
  logic [45:0] m_pa_r;
  logic [45:0] m_pb_r;
  logic        c_v_r;
  logic        c_op_r;
  logic [KD-1:0] c_xa_r;
  logic [KD-1:0] c_xb_r;

  function automatic logic [KD-1:0] us_biased(input logic [45:0] p);
    logic [43:0]   us;
    logic [KD-1:0] x;
    us = p[45:2];
    if (|us[43:33]) begin
      x = {1'b1, 33'b0};
    end else begin
      x = {1'b0, us[32:0]};
    end
    return x + KD'(MS_ROUND);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      m_v_r <= sd_v_r[SD-1];
      c_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    m_op_r <= sd_op_r[SD-1];
    m_pa_r <= 46'(sd_qa_r[SD-1]) * 46'(sd_dq_r[SD-1]);
    m_pb_r <= 46'(sd_qb_r[SD-1]) * 46'(sd_dq_r[SD-1]);
    c_op_r <= m_op_r;
    c_xa_r <= us_biased(m_pa_r);
    c_xb_r <= us_biased(m_pb_r);
  end

  // divide by 1000: drop three bits, then multiply by the reciprocal of 125
  logic        k_v_r;
  logic        k_op_r;
  logic [62:0] k_pa_r;
  logic [62:0] k_pb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_v_r <= 1'b0;
    end else begin
      k_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    k_op_r <= c_op_r;
    k_pa_r <= 63'(c_xa_r[KD-1:3]) * 63'(MS_RECIP);
    k_pb_r <= 63'(c_xb_r[KD-1:3]) * 63'(MS_RECIP);
  end

  // final select, ack sum and saturation
  logic [23:0]     ms_a;
  logic [23:0]     ms_b;
  logic [25:0]     ack_sum;
  logic [25:0]     t_sel;
  logic            out_valid_r;
  logic [MS_W-1:0] out_time_ms_r;

  assign ms_a    = k_pa_r[61:38];
  assign ms_b    = k_pb_r[61:38];
  assign ack_sum = {1'b0, ms_a, 1'b0} + {2'b0, ms_b} + 26'(ACK_MS);
  assign t_sel   = k_op_r ? ack_sum : {2'b0, ms_a};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= k_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_time_ms_r <= (t_sel > 26'(MS_MAX)) ? MS_MAX : t_sel[MS_W-1:0];
  end

  assign out_valid   = out_valid_r;
  assign out_time_ms = out_time_ms_r;

endmodule

`default_nettype wire

// ----- hw/rtl/toa_chk.sv -----
// port-level checker for the lora time-on-air block and its bind
`default_nettype none

module toa_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      in_operation,
  input logic                      out_valid,
  input logic [toa_pkg::MS_W-1:0]  out_time_ms
);

  import toa_pkg::*;

  a_item_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted item");

  a_ack_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && !busy && in_operation, LATENCY))
      |-> (out_time_ms >= MS_W'(ACK_MS)))
    else $error("ack timeout below fixed margin");

  a_ready_out_of_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised outside reset");

endmodule

bind lora_time_on_air_core toa_chk u_toa_chk (.*);

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the lora time-on-air core
module tb_top;
  import toa_pkg::*;

  typedef struct packed {
    logic             op;
    logic [LEN_W-1:0] len;
  } toa_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_operation = 1'b0;
  logic [LEN_W-1:0]     in_payload_len = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 out_valid;
  logic [MS_W-1:0]      out_time_ms;

  toa_req_t        pending_reqs[$];
  logic [MS_W-1:0] expected_ms_q[$];
  int              mismatch_cnt = 0;
  int              idle_pct = 10;

  logic [SF_W-1:0]  cur_sf = SF_RST;
  logic [BW_W-1:0]  cur_bw = BW_RST;
  logic [CR_W-1:0]  cur_cr = CR_RST;
  logic [PRE_W-1:0] cur_pre = PRE_RST;
  logic             cur_crc = 1'b1;

  lora_time_on_air_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_payload_len (in_payload_len),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_time_ms    (out_time_ms)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_cnt++;
  endtask

  // packet airtime in ms under the current register settings, unsaturated
  function automatic longint unsigned frame_airtime_ms(input logic [LEN_W-1:0] len);
    longint unsigned sf, bw, sym_us, pre_us, den, nsym, total_us;
    longint          num, len_s, sf_s, den_s;
    sf = cur_sf;
    if (sf < SF_MIN) sf = SF_MIN;
    if (sf > SF_MAX) sf = SF_MAX;
    bw = cur_bw;
    if (bw == 0) bw = 1;
    sym_us = ((64'd1 << sf) * 64'd1000000) / bw;
    pre_us = (cur_pre * 64'd4 + 64'd17) * sym_us / 64'd4;
    den = (sf >= SF_LDRO) ? 4 * (sf - 2) : 4 * sf;
    len_s = len;
    sf_s = sf;
    den_s = den;
    num = 8 * len_s - 4 * sf_s + 28 + (cur_crc ? 16 : 0);
    nsym = 0;
    if (num > 0) nsym = (num + den_s - 1) / den_s;
    total_us = pre_us + (64'd8 + nsym * (cur_cr + 64'd4)) * sym_us;
    return (total_us + 64'd999) / 64'd1000;
  endfunction

  function automatic logic [MS_W-1:0] predict_time_ms(input logic op,
                                                      input logic [LEN_W-1:0] len);
    longint unsigned t;
    if (op) t = 2 * frame_airtime_ms(len) + frame_airtime_ms(ACK_LEN) + ACK_MS;
    else t = frame_airtime_ms(len);
    if (t > MS_MAX) t = MS_MAX;
    return t[MS_W-1:0];
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n && pending_reqs.size() != 0 &&
        ((start && busy) || $urandom_range(0, 99) >= idle_pct)) begin
      start          <= 1'b1;
      in_operation   <= pending_reqs[0].op;
      in_payload_len <= pending_reqs[0].len;
    end else begin
      start          <= 1'b0;
      in_operation   <= 1'($urandom);
      in_payload_len <= LEN_W'($urandom);
    end
  end

  // monitor: checks results, predicts accepted items, tracks register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      cur_sf  <= SF_RST;
      cur_bw  <= BW_RST;
      cur_cr  <= CR_RST;
      cur_pre <= PRE_RST;
      cur_crc <= 1'b1;
    end else begin
      if (out_valid) begin
        if (expected_ms_q.size() == 0) begin
          report_mismatch($sformatf("time_ms %0d with no item outstanding", out_time_ms));
        end else begin
          if (out_time_ms !== expected_ms_q[0])
            report_mismatch($sformatf("time_ms got %0d expected %0d",
                                      out_time_ms, expected_ms_q[0]));
          void'(expected_ms_q.pop_front());
        end
      end
      if (start && !busy) begin
        expected_ms_q.push_back(predict_time_ms(in_operation, in_payload_len));
        void'(pending_reqs.pop_front());
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SF:  cur_sf  <= cfg_wdata[SF_W-1:0];
          CFG_BW:  cur_bw  <= cfg_wdata[BW_W-1:0];
          CFG_CR:  cur_cr  <= cfg_wdata[CR_W-1:0];
          CFG_PRE: cur_pre <= cfg_wdata[PRE_W-1:0];
          CFG_CRC: cur_crc <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  task automatic push_req(input logic op, input logic [LEN_W-1:0] len);
    toa_req_t req;
    req.op = op;
    req.len = len;
    pending_reqs.push_back(req);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_ms_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [SF_W-1:0] sf, input logic [BW_W-1:0] bw,
                          input logic [CR_W-1:0] cr, input logic [PRE_W-1:0] pre,
                          input logic crc);
    write_reg(CFG_SF, sf);
    write_reg(CFG_BW, bw);
    write_reg(CFG_CR, cr);
    write_reg(CFG_PRE, pre);
    write_reg(CFG_CRC, crc);
    cfg_we <= 1'b0;
  endtask

  // random items, with a full drain halfway through
  task automatic push_random(input int n);
    logic [LEN_W-1:0] len;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      if ($urandom_range(0, 7) == 0) len = $urandom_range(0, 1) ? '1 : '0;
      else len = LEN_W'($urandom_range(0, 255));
      push_req(1'($urandom_range(0, 1)), len);
    end
  endtask

  initial begin : stimulus
    logic [LEN_W-1:0] corner_len [6];
    corner_len = '{8'd0, 8'd1, 8'd8, 8'd127, 8'd128, 8'd255};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (corner_len[i]) begin
      push_req(1'b0, corner_len[i]);
      push_req(1'b1, corner_len[i]);
    end
    push_random(74);
    drain();

    // negative payload symbol term
    set_regs(4'd12, 19'd500000, 3'd4, 10'd6, 1'b0);
    push_req(1'b0, 8'd0);
    push_req(1'b0, 8'd2);
    push_req(1'b1, 8'd0);
    push_random(74);
    drain();

    // zero bandwidth, low spreading factor, coding rate zero, saturation
    set_regs(4'd0, 19'd0, 3'd0, 10'd1023, 1'b0);
    push_req(1'b0, 8'd0);
    push_req(1'b1, 8'd255);
    push_random(74);
    drain();

    // high spreading factor, coding rate above range
    set_regs(4'd15, 19'd7800, 3'd7, 10'd0, 1'b1);
    push_req(1'b0, 8'd255);
    push_req(1'b1, 8'd1);
    push_random(74);
    drain();

    set_regs(4'd5, 19'd500000, 3'd5, 10'd6, 1'b1);
    push_req(1'b0, 8'd0);
    push_req(1'b1, 8'd255);
    push_random(74);
    drain();

    set_regs(4'd12, 19'd7800, 3'd4, 10'd1023, 1'b1);
    push_req(1'b0, 8'd255);
    push_req(1'b1, 8'd255);
    push_random(74);
    drain();

    for (int p = 6; p < 17; p++) begin
      idle_pct = (p < 12) ? 71 : 0;
      if ($urandom_range(0, 4) == 0)
        set_regs(SF_W'($urandom_range(0, 15)), BW_W'($urandom_range(0, (1 << BW_W) - 1)),
                 CR_W'($urandom_range(0, 7)), PRE_W'($urandom_range(0, 1023)),
                 1'($urandom_range(0, 1)));
      else
        set_regs(SF_W'($urandom_range(5, 12)), BW_W'($urandom_range(7800, 500000)),
                 CR_W'($urandom_range(1, 4)),
                 PRE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(6, 1023)
                                                    : $urandom_range(6, 16)),
                 1'($urandom_range(0, 1)));
      push_random(74);
      drain();
    end

    repeat (LATENCY + 8) @(negedge clk);
    if (mismatch_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/toa_pkg.sv
hw/rtl/lora_time_on_air_core.sv
hw/rtl/toa_chk.sv
verif/tb_top.sv
